/* rtl/core/bsq_pkg.sv */
// Shared types and constants for the bounded stack/queue block.
`default_nettype none

package bsq_pkg;

  // Field widths of the request and result records.
  localparam int unsigned ReqTypeBits = 2;
  localparam int unsigned DataBits    = 32;
  localparam int unsigned StatusBits  = 2;
  localparam int unsigned CountBits   = 11;

  // Default sizing of the store.
  localparam int unsigned DefDepth    = 1024;
  localparam int unsigned DefWordBits = 32;

  // Request kinds.
  localparam logic [ReqTypeBits-1:0] REQ_PUSH_TOP    = 2'd0;
  localparam logic [ReqTypeBits-1:0] REQ_PUSH_BOTTOM = 2'd1;
  localparam logic [ReqTypeBits-1:0] REQ_POP_TOP     = 2'd2;
  localparam logic [ReqTypeBits-1:0] REQ_CLEAR       = 2'd3;

  // Result status codes.
  localparam logic [StatusBits-1:0] ST_OK        = 2'd0;
  localparam logic [StatusBits-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [StatusBits-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [ReqTypeBits-1:0]   req_type;
    logic signed [DataBits-1:0] data_word;
  } bsq_req_t;

  typedef struct packed {
    logic signed [DataBits-1:0] popped_word;
    logic [StatusBits-1:0]      status;
    logic                       is_empty;
    logic [CountBits-1:0]       entry_count;
  } bsq_rsp_t;

  // Operation broadcast from the controller to the cell row.
  typedef struct packed {
    logic push_top;
    logic push_bottom;
    logic pop;
  } bsq_chain_ctl_t;

  // Per-cell load selects.
  typedef struct packed {
    logic take_word;
    logic take_above;
    logic take_below;
  } bsq_cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/bounded_stack_queue.sv */
// Top level of the bounded stack/queue: request handling, fill count and result register.
`default_nettype none

// A bounded store of DEPTH signed words that works as a stack with an extra
// push beneath the bottom entry. Every request (push top, push bottom, pop top,
// clear) yields exactly one result with status, popped word, entry count and
// empty flag. The words sit in a row of cells, top of stack in the first cell;
// a push top or a pop shifts the whole row by one cell, and a push bottom
// loads the first free cell. A new request is taken every cycle as long as
// the result register is free or is being drained in the same cycle. Results
// are registered and appear in the cycle after the request is taken. Words are
// kept as their low WORD_BITS bits (at most 32) and returned zero-extended.
// There is no start-up sweep after reset.
module bounded_stack_queue #(
  parameter int unsigned DEPTH     = bsq_pkg::DefDepth,
  parameter int unsigned WORD_BITS = bsq_pkg::DefWordBits
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire bsq_pkg::bsq_req_t in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output bsq_pkg::bsq_rsp_t  out_data
);

  localparam int unsigned CntBits = $clog2(DEPTH + 1);
  localparam int unsigned StoreBits =
    (WORD_BITS < bsq_pkg::DataBits) ? WORD_BITS : bsq_pkg::DataBits;

  logic [CntBits-1:0]      count_r;
  logic [CntBits-1:0]      count_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  bsq_pkg::bsq_rsp_t       out_r;
  bsq_pkg::bsq_rsp_t       rsp;
  bsq_pkg::bsq_chain_ctl_t chain_ctl;
  logic [StoreBits-1:0]    top_word;
  logic                    in_accept;
  logic                    full;
  logic                    empty;

  // A request is taken whenever the result register is free or drains now.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign full      = (count_r == CntBits'(DEPTH));
  assign empty     = (count_r == '0);

  // Decode the request into a cell operation, the new count and the result.
  always_comb begin
    chain_ctl       = '0;
    count_nxt       = count_r;
    rsp.popped_word = '0;
    rsp.status      = bsq_pkg::ST_OK;
    case (in_data.req_type)
      bsq_pkg::REQ_PUSH_TOP: begin
        if (full) begin
          rsp.status = bsq_pkg::ST_OVERFLOW;
        end else begin
          chain_ctl.push_top = in_accept;
          count_nxt          = count_r + 1'b1;
        end
      end
      bsq_pkg::REQ_PUSH_BOTTOM: begin
        if (full) begin
          rsp.status = bsq_pkg::ST_OVERFLOW;
        end else begin
          chain_ctl.push_bottom = in_accept;
          count_nxt             = count_r + 1'b1;
        end
      end
      bsq_pkg::REQ_POP_TOP: begin
        if (empty) begin
          rsp.status = bsq_pkg::ST_UNDERFLOW;
        end else begin
          chain_ctl.pop   = in_accept;
          count_nxt       = count_r - 1'b1;
          rsp.popped_word = bsq_pkg::DataBits'(top_word);
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
    rsp.is_empty    = (count_nxt == '0);
    rsp.entry_count = bsq_pkg::CountBits'(count_nxt);
  end

  // The cell row holding the stored words.
  bsq_chain #(
    .DEPTH (DEPTH),
    .W     (StoreBits)
  ) u_chain (
    .clk      (clk),
    .ctl      (chain_ctl),
    .count    (count_r),
    .word     (in_data.data_word[StoreBits-1:0]),
    .top_word (top_word)
  );

  // Result valid follows accepted requests and clears when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntBits'(DEPTH))
    else $error("fill count above capacity");

  // A refused push leaves the count alone.
  a_overflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && full && (in_data.req_type == bsq_pkg::REQ_PUSH_TOP ||
                          in_data.req_type == bsq_pkg::REQ_PUSH_BOTTOM)
    |=> count_r == $past(count_r))
    else $error("count changed on a refused push");

  // A pop on a non-empty store removes exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !empty && in_data.req_type == bsq_pkg::REQ_POP_TOP
    |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not remove one entry");

  // Every taken request produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("no result after a taken request");

  // The held result's empty flag agrees with the current count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.is_empty == (count_r == '0))
    else $error("empty flag disagrees with fill count");

endmodule

`default_nettype wire

/* rtl/core/bsq_cell.sv */
// One storage cell of the stack row: holds a word, loads from a neighbor or the new word.
`default_nettype none

module bsq_cell #(
  parameter int unsigned W = bsq_pkg::DefWordBits
) (
  input  wire                     clk,
  input  wire bsq_pkg::bsq_cell_ctl_t ctl,
  input  wire  [W-1:0]            word,
  input  wire  [W-1:0]            above,
  input  wire  [W-1:0]            below,
  output logic [W-1:0]            q
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  // Pick the next content: a new word, the neighbor above, the neighbor below, or hold.
  always_comb begin
    data_nxt = data_r;
    if (ctl.take_word) begin
      data_nxt = word;
    end else if (ctl.take_above) begin
      data_nxt = above;
    end else if (ctl.take_below) begin
      data_nxt = below;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

/* rtl/core/bsq_chain.sv */
// Row of storage cells, top of stack at cell 0, bottom entry at cell count-1.
`default_nettype none

module bsq_chain #(
  parameter int unsigned DEPTH = bsq_pkg::DefDepth,
  parameter int unsigned W     = bsq_pkg::DefWordBits,
  localparam int unsigned CntBits = $clog2(DEPTH + 1)
) (
  input  wire                      clk,
  input  wire bsq_pkg::bsq_chain_ctl_t ctl,
  input  wire  [CntBits-1:0]       count,
  input  wire  [W-1:0]             word,
  output logic [W-1:0]             top_word
);

  logic [W-1:0] cell_q [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      bsq_pkg::bsq_cell_ctl_t cell_ctl;
      logic [W-1:0]           above;
      logic [W-1:0]           below;

      // Push top shifts every cell down by one; pop shifts every cell but the last up by one.
      // Push bottom writes the word into the first free cell only.
      always_comb begin
        cell_ctl.take_word  = ctl.push_bottom && (count == CntBits'(i));
        cell_ctl.take_above = ctl.push_top;
        cell_ctl.take_below = ctl.pop && (i < DEPTH - 1);
      end

      if (i == 0) begin : g_first
        assign above = word;
      end else begin : g_inner
        assign above = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign below = cell_q[i];
      end else begin : g_mid
        assign below = cell_q[i+1];
      end

      bsq_cell #(.W(W)) u_cell (
        .clk   (clk),
        .ctl   (cell_ctl),
        .word  (word),
        .above (above),
        .below (below),
        .q     (cell_q[i])
      );
    end
  endgenerate

  assign top_word = cell_q[0];

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the bounded stack/queue: directed table, random traffic, idling.
`timescale 1ns / 100ps

module testbench;
  import bsq_pkg::*;

  localparam int unsigned RingDepth   = DefDepth;
  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned HoldOffLen  = 300;
  localparam int unsigned PrintLimit  = 50;

  typedef logic [$clog2(RingDepth)-1:0] slot_t;

  // One row of the directed table: a request and, where it is obvious, its result.
  typedef struct {
    bsq_req_t req;
    bit       typed;
    bsq_rsp_t want;
  } stimulus_row_t;

  localparam bsq_rsp_t EmptyOk        = '{32'sd0, ST_OK, 1'b1, 11'd0};
  localparam bsq_rsp_t EmptyUnderflow = '{32'sd0, ST_UNDERFLOW, 1'b1, 11'd0};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  bsq_req_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bsq_rsp_t out_data;

  // Shadow copy of the store used to predict every result.
  logic [DataBits-1:0] store_words [RingDepth];
  slot_t               store_base = '0;
  int unsigned         store_fill = 0;

  bsq_rsp_t    pending_rsp [$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  int unsigned idle_by_phase  [4] = '{0, 79, 0, 8};
  int unsigned stall_by_phase [4] = '{0, 0, 79, 8};

  stimulus_row_t directed_rows [23] = '{
    '{'{REQ_POP_TOP,     32'sd0},           1'b1, EmptyUnderflow},
    '{'{REQ_CLEAR,       32'sd0},           1'b1, EmptyOk},
    '{'{REQ_PUSH_TOP,    32'sh7fff_ffff},   1'b1, '{32'sd0, ST_OK, 1'b0, 11'd1}},
    '{'{REQ_PUSH_BOTTOM, 32'sh8000_0000},   1'b1, '{32'sd0, ST_OK, 1'b0, 11'd2}},
    '{'{REQ_POP_TOP,     32'sd0},           1'b1, '{32'sh7fff_ffff, ST_OK, 1'b0, 11'd1}},
    '{'{REQ_POP_TOP,     32'sd0},           1'b1, '{32'sh8000_0000, ST_OK, 1'b1, 11'd0}},
    '{'{REQ_POP_TOP,     32'sd0},           1'b1, EmptyUnderflow},
    '{'{REQ_PUSH_TOP,    32'shffff_ffff},   1'b0, '0},
    '{'{REQ_PUSH_BOTTOM, 32'sh0000_0000},   1'b0, '0},
    '{'{REQ_PUSH_TOP,    32'sh5555_5555},   1'b0, '0},
    '{'{REQ_PUSH_BOTTOM, 32'shaaaa_aaaa},   1'b0, '0},
    '{'{REQ_POP_TOP,     32'sd0},           1'b0, '0},
    '{'{REQ_PUSH_TOP,    32'sh0000_0001},   1'b0, '0},
    '{'{REQ_CLEAR,       32'sh1234_5678},   1'b1, EmptyOk},
    '{'{REQ_POP_TOP,     32'sd0},           1'b1, EmptyUnderflow},
    '{'{REQ_PUSH_BOTTOM, 32'sh1234_5678},   1'b0, '0},
    '{'{REQ_PUSH_BOTTOM, 32'sh9abc_def0},   1'b0, '0},
    '{'{REQ_POP_TOP,     32'sd0},           1'b0, '0},
    '{'{REQ_POP_TOP,     32'sd0},           1'b0, '0},
    '{'{REQ_POP_TOP,     32'sd0},           1'b1, EmptyUnderflow},
    '{'{REQ_PUSH_TOP,    32'sh8000_0000},   1'b0, '0},
    '{'{REQ_CLEAR,       32'shffff_ffff},   1'b1, EmptyOk},
    '{'{REQ_POP_TOP,     32'shffff_ffff},   1'b1, EmptyUnderflow}
  };

  bounded_stack_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the shadow store and returns the result it should give.
  function automatic bsq_rsp_t apply_request(input bsq_req_t req);
    bsq_rsp_t rsp;
    slot_t    slot;
    rsp = '0;
    rsp.status = ST_OK;
    case (req.req_type)
      REQ_PUSH_TOP: begin
        if (store_fill == RingDepth) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          slot = store_base + slot_t'(store_fill);
          store_words[slot] = req.data_word;
          store_fill++;
        end
      end
      REQ_PUSH_BOTTOM: begin
        if (store_fill == RingDepth) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          store_base = store_base - slot_t'(1);
          store_words[store_base] = req.data_word;
          store_fill++;
        end
      end
      REQ_POP_TOP: begin
        if (store_fill == 0) begin
          rsp.status = ST_UNDERFLOW;
        end else begin
          store_fill--;
          slot = store_base + slot_t'(store_fill);
          rsp.popped_word = store_words[slot];
        end
      end
      default: begin
        store_fill = 0;
        store_base = '0;
      end
    endcase
    rsp.is_empty = (store_fill == 0);
    rsp.entry_count = CountBits'(store_fill);
    return rsp;
  endfunction

  // Random request; the push and clear shares are given in percent.
  function automatic bsq_req_t random_request(input int unsigned push_pct,
                                              input int unsigned clear_pct);
    bsq_req_t    req;
    int unsigned roll;
    roll = $urandom_range(99);
    req.data_word = $urandom;
    if (roll < clear_pct) begin
      req.req_type = REQ_CLEAR;
    end else if (roll < clear_pct + push_pct * (100 - clear_pct) / 100) begin
      req.req_type = $urandom_range(1) ? REQ_PUSH_TOP : REQ_PUSH_BOTTOM;
    end else begin
      req.req_type = REQ_POP_TOP;
    end
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PrintLimit) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [DataBits-1:0] got,
                             input logic [DataBits-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Offers one request, holding it until the block takes it, then records its result.
  task automatic send_request(input bsq_req_t req, input bit typed, input bsq_rsp_t want);
    bsq_rsp_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_request(req);
    pending_rsp.push_back(typed ? want : predicted);
  endtask

  // Withdraws the last request and waits until every expected result has come.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Runs of mostly pushes, balanced traffic or mostly pops, so the depth wanders widely.
  task automatic random_traffic(input int unsigned count);
    int unsigned push_pct;
    int unsigned run_left;
    push_pct = 50;
    run_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(50, 10);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      run_left--;
      send_request(random_request(push_pct, 3), 1'b0, '0);
    end
  endtask

  // Receiver: a counted hold-off when one is pending, else random stalls.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compares every result taken from the block with the oldest expected one.
  always @(posedge clk) begin
    bsq_rsp_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        want = pending_rsp.pop_front();
        check_field("popped_word", out_data.popped_word, want.popped_word);
        check_field("status", DataBits'(out_data.status), DataBits'(want.status));
        check_field("is_empty", DataBits'(out_data.is_empty), DataBits'(want.is_empty));
        check_field("entry_count", DataBits'(out_data.entry_count),
                    DataBits'(want.entry_count));
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table with no idling on either side.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_for_results();

    // Random traffic under each idling pattern.
    for (int unsigned phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_by_phase[phase];
      recv_stall_pct = stall_by_phase[phase];
      random_traffic(110);
      wait_for_results();
    end

    // Long receiver hold-off while requests keep coming at full rate.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = HoldOffLen;
    random_traffic(40);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
